[rtl/fsp_pkg.sv]
// shared types, constants and the report word selection for the read-file profiler
package fsp_pkg;

    localparam int MAX_READ_LEN = 1024;
    localparam int MARK_AW      = $clog2(MAX_READ_LEN);
    localparam int SYMBOLS      = 256;
    localparam int IDX_W        = 5;
    localparam int WORD_W       = 64;
    localparam int POS_W        = 32;

    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_N   = 8'h4E;
    localparam logic [7:0] CHAR_DOT = 8'h2E;

    localparam logic [2:0] PLUS_PLAIN_LEN = 3'd3;
    localparam logic [2:0] PLUS_SAT       = 3'd4;

    // report word indexes
    localparam logic [IDX_W-1:0] RPT_HDR_MAP   = 5'd0;
    localparam logic [IDX_W-1:0] RPT_BASE_MAP  = 5'd4;
    localparam logic [IDX_W-1:0] RPT_QUAL_MAP  = 5'd8;
    localparam logic [IDX_W-1:0] RPT_HDR_CNT   = 5'd12;
    localparam logic [IDX_W-1:0] RPT_BASE_CNT  = 5'd13;
    localparam logic [IDX_W-1:0] RPT_QUAL_CNT  = 5'd14;
    localparam logic [IDX_W-1:0] RPT_READ_CNT  = 5'd15;
    localparam logic [IDX_W-1:0] RPT_HDR_LONG  = 5'd16;
    localparam logic [IDX_W-1:0] RPT_QUAL_LONG = 5'd17;
    localparam logic [IDX_W-1:0] RPT_FLAGS     = 5'd18;
    localparam logic [IDX_W-1:0] RPT_LAST      = RPT_FLAGS;

    typedef enum logic [1:0] {
        LINE_HEADER,
        LINE_BASES,
        LINE_PLUS,
        LINE_QUALITY
    } line_kind_t;

    typedef enum logic [1:0] {
        CHK_WAIT_N,
        CHK_TRACK,
        CHK_FAILED
    } check_mode_t;

    typedef enum logic [1:0] {
        PH_RUN,
        PH_REPORT,
        PH_CLEAR
    } phase_t;

    typedef struct packed {
        logic [SYMBOLS-1:0] header_seen;
        logic [SYMBOLS-1:0] base_seen;
        logic [SYMBOLS-1:0] quality_seen;
        logic [WORD_W-1:0]  header_count;
        logic [WORD_W-1:0]  base_count;
        logic [WORD_W-1:0]  quality_count;
        logic [WORD_W-1:0]  read_count;
        logic [POS_W-1:0]   longest_header;
        logic [POS_W-1:0]   longest_quality;
        logic               extra_header;
        logic               varying_length;
        logic               score_mismatch;
    } stats_t;

    localparam stats_t STATS_INIT = '{
        header_seen:     '0,
        base_seen:       '0,
        quality_seen:    '0,
        header_count:    '0,
        base_count:      '0,
        quality_count:   '0,
        read_count:      '0,
        longest_header:  32'd1,
        longest_quality: 32'd1,
        extra_header:    1'b1,
        varying_length:  1'b0,
        score_mismatch:  1'b0
    };

    typedef struct packed {
        logic               en;
        logic [MARK_AW-1:0] addr;
        logic               data;
    } mark_wr_t;

    function automatic logic [WORD_W-1:0] report_word(input stats_t s,
                                                       input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        w = '0;
        priority if (idx < RPT_BASE_MAP)
            w = s.header_seen[WORD_W*idx[1:0] +: WORD_W];
        else if (idx < RPT_QUAL_MAP)
            w = s.base_seen[WORD_W*idx[1:0] +: WORD_W];
        else if (idx < RPT_HDR_CNT)
            w = s.quality_seen[WORD_W*idx[1:0] +: WORD_W];
        else if (idx == RPT_HDR_CNT)
            w = s.header_count;
        else if (idx == RPT_BASE_CNT)
            w = s.base_count;
        else if (idx == RPT_QUAL_CNT)
            w = s.quality_count;
        else if (idx == RPT_READ_CNT)
            w = s.read_count;
        else if (idx == RPT_HDR_LONG)
            w = {{(WORD_W-POS_W){1'b0}}, s.longest_header};
        else if (idx == RPT_QUAL_LONG)
            w = {{(WORD_W-POS_W){1'b0}}, s.longest_quality};
        else if (idx == RPT_FLAGS)
            w = {{(WORD_W-3){1'b0}}, s.score_mismatch, s.varying_length, s.extra_header};
        else
            w = '0;
        return w;
    endfunction

endpackage

[rtl/fsp_if.sv]
// valid/ready channel interfaces for the byte stream and the report words
interface fsp_in_if
    import fsp_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface fsp_out_if
    import fsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  report_index;
    logic [WORD_W-1:0] report_value;
    logic              report_last;

    modport source (output valid, output report_index, output report_value,
                    output report_last, input ready);
    modport sink   (input valid, input report_index, input report_value,
                    input report_last, output ready);
endinterface

[rtl/fsp_ram.sv]
// generic simple dual-port ram, one write and one registered read port
module fsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fsp_parser.sv]
// line parser: walks the four line kinds and keeps bitmaps, counts and flags
module fsp_parser
    import fsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               clear,
    input  logic               mark_rd,
    output logic [MARK_AW-1:0] mark_raddr,
    output mark_wr_t           mark_wr,
    output stats_t             stats
);

    line_kind_t       line_kind_reg, line_kind_next;
    check_mode_t      check_mode_reg, check_mode_next;
    logic [POS_W-1:0] line_pos_reg, line_pos_next;
    logic [2:0]       plus_cnt_reg, plus_cnt_next;
    logic [7:0]       low_sym_reg, low_sym_next;
    logic             in_range_reg, in_range_next;
    stats_t           stats_reg, stats_next;

    logic [POS_W-1:0] pos_inc;
    logic [2:0]       plus_sat;
    logic             is_nl;
    logic             mark;

    assign pos_inc  = line_pos_reg + 32'd1;
    assign plus_sat = (plus_cnt_reg < PLUS_SAT) ? plus_cnt_reg + 3'd1 : plus_cnt_reg;
    assign is_nl    = (data_byte == CHAR_NL);
    // marks beyond the memory read as zero
    assign mark     = mark_rd & in_range_reg;

    always_comb
    begin
        line_kind_next  = line_kind_reg;
        check_mode_next = check_mode_reg;
        line_pos_next   = line_pos_reg;
        plus_cnt_next   = plus_cnt_reg;
        low_sym_next    = low_sym_reg;
        stats_next      = stats_reg;
        if (clear)
        begin
            line_kind_next  = LINE_HEADER;
            check_mode_next = CHK_WAIT_N;
            line_pos_next   = '0;
            plus_cnt_next   = '0;
            low_sym_next    = '0;
            stats_next      = STATS_INIT;
        end
        else if (accept)
        begin
            unique case (line_kind_reg)
                LINE_HEADER:
                begin
                    line_pos_next = pos_inc;
                    if (stats_reg.longest_header < pos_inc)
                        stats_next.longest_header = pos_inc;
                    if (is_nl)
                    begin
                        line_kind_next = LINE_BASES;
                        line_pos_next  = '0;
                    end
                    else
                    begin
                        stats_next.header_count = stats_reg.header_count + 64'd1;
                        stats_next.header_seen[data_byte] = 1'b1;
                    end
                end
                LINE_BASES:
                begin
                    line_pos_next = pos_inc;
                    if (is_nl)
                        line_kind_next = LINE_PLUS;
                    else
                    begin
                        stats_next.base_count = stats_reg.base_count + 64'd1;
                        stats_next.base_seen[data_byte] = 1'b1;
                    end
                end
                LINE_PLUS:
                begin
                    plus_cnt_next = plus_sat;
                    if (is_nl)
                    begin
                        // a plus line of exactly two bytes before its newline clears the extra header flag
                        if (plus_sat == PLUS_PLAIN_LEN)
                            stats_next.extra_header = 1'b0;
                        plus_cnt_next  = '0;
                        line_kind_next = LINE_QUALITY;
                        line_pos_next  = '0;
                    end
                end
                LINE_QUALITY:
                begin
                    unique case (check_mode_reg)
                        CHK_WAIT_N:
                        begin
                            if (mark)
                            begin
                                if (stats_reg.quality_seen[data_byte])
                                begin
                                    stats_next.score_mismatch = 1'b1;
                                    check_mode_next = CHK_FAILED;
                                end
                                else
                                begin
                                    low_sym_next    = data_byte;
                                    check_mode_next = CHK_TRACK;
                                end
                            end
                        end
                        CHK_TRACK:
                        begin
                            if ((data_byte == low_sym_reg) != mark)
                            begin
                                stats_next.score_mismatch = 1'b1;
                                check_mode_next = CHK_FAILED;
                            end
                        end
                        default:
                        begin
                            check_mode_next = check_mode_reg;
                        end
                    endcase
                    line_pos_next = pos_inc;
                    if (stats_reg.longest_quality < pos_inc)
                        stats_next.longest_quality = pos_inc;
                    stats_next.quality_seen[data_byte] = 1'b1;
                    if (is_nl)
                    begin
                        stats_next.read_count = stats_reg.read_count + 64'd1;
                        line_kind_next = LINE_HEADER;
                        if (pos_inc != stats_next.longest_quality)
                            stats_next.varying_length = 1'b1;
                        line_pos_next = '0;
                    end
                    else
                    begin
                        stats_next.quality_count = stats_reg.quality_count + 64'd1;
                    end
                end
                default:
                begin
                    line_kind_next = line_kind_reg;
                end
            endcase
        end
    end

    // read address runs one byte ahead so the mark is ready when the byte arrives
    assign in_range_next = (line_pos_next < POS_W'(MAX_READ_LEN));
    assign mark_raddr    = line_pos_next[MARK_AW-1:0];

    always_comb
    begin
        mark_wr.en   = accept && !clear && (line_kind_reg == LINE_BASES) && !is_nl
                       && (line_pos_reg < POS_W'(MAX_READ_LEN));
        mark_wr.addr = line_pos_reg[MARK_AW-1:0];
        mark_wr.data = (data_byte == CHAR_N) || (data_byte == CHAR_DOT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_kind_reg  <= LINE_HEADER;
            check_mode_reg <= CHK_WAIT_N;
            line_pos_reg   <= '0;
            plus_cnt_reg   <= '0;
            low_sym_reg    <= '0;
            in_range_reg   <= 1'b1;
            stats_reg      <= STATS_INIT;
        end
        else
        begin
            line_kind_reg  <= line_kind_next;
            check_mode_reg <= check_mode_next;
            line_pos_reg   <= line_pos_next;
            plus_cnt_reg   <= plus_cnt_next;
            low_sym_reg    <= low_sym_next;
            in_range_reg   <= in_range_next;
            stats_reg      <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

[rtl/fastq_stream_profiler_unit.sv]
// top level of the read-file profiler: parser, position-mark memory, report sequencer
// Takes one byte per cycle with no gaps of its own; a byte is processed in the
// cycle it is taken. After the byte flagged end_of_stream the unit stops taking
// bytes and sends 19 report words (index 0 to 18, last flag on 18), one per
// cycle when the sink is ready. It then clears all MAX_READ_LEN (1024) entries
// of the position-mark memory, one entry per cycle, and statistics start again
// from their reset values. The same clearing pass runs after reset before the
// first byte is taken. The last report word may still wait in the output
// register while new bytes flow in.
module fastq_stream_profiler_unit
    import fsp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    fsp_in_if.sink   byte_ch,
    fsp_out_if.source report_ch
);

    phase_t             phase_reg, phase_next;
    logic [IDX_W-1:0]   word_idx_reg, word_idx_next;
    logic [MARK_AW-1:0] clr_addr_reg, clr_addr_next;

    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_index_reg;
    logic [WORD_W-1:0]  out_value_reg;
    logic               out_last_reg;

    logic               in_ready;
    logic               accept;
    logic               out_free;
    logic               load_word;
    logic               clear_stats;
    logic               ram_clear;
    logic               clr_done;

    logic               mark_rd;
    logic [MARK_AW-1:0] mark_raddr;
    mark_wr_t           mark_wr;
    stats_t             stats;

    logic               ram_we;
    logic [MARK_AW-1:0] ram_waddr;
    logic               ram_wdata;

    assign accept   = byte_ch.valid && in_ready;
    assign out_free = !out_valid_reg || report_ch.ready;
    assign clr_done = (clr_addr_reg == MARK_AW'(MAX_READ_LEN - 1));

    // next phase
    always_comb
    begin
        phase_next    = phase_reg;
        word_idx_next = word_idx_reg;
        clr_addr_next = clr_addr_reg;
        unique case (phase_reg)
            PH_RUN:
            begin
                if (accept && byte_ch.end_of_stream)
                begin
                    phase_next    = PH_REPORT;
                    word_idx_next = '0;
                end
            end
            PH_REPORT:
            begin
                if (out_free)
                begin
                    word_idx_next = word_idx_reg + 5'd1;
                    if (word_idx_reg == RPT_LAST)
                    begin
                        phase_next    = PH_CLEAR;
                        clr_addr_next = '0;
                    end
                end
            end
            PH_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + MARK_AW'(1);
                if (clr_done)
                    phase_next = PH_RUN;
            end
            default:
            begin
                phase_next = PH_CLEAR;
            end
        endcase
    end

    // phase outputs
    always_comb
    begin
        in_ready    = 1'b0;
        load_word   = 1'b0;
        clear_stats = 1'b0;
        ram_clear   = 1'b0;
        unique case (phase_reg)
            PH_RUN:
            begin
                in_ready = 1'b1;
            end
            PH_REPORT:
            begin
                load_word   = out_free;
                clear_stats = out_free && (word_idx_reg == RPT_LAST);
            end
            PH_CLEAR:
            begin
                ram_clear = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_word)
            out_valid_next = 1'b1;
        else if (report_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CLEAR;
            word_idx_reg  <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            word_idx_reg  <= word_idx_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_word)
        begin
            out_index_reg <= word_idx_reg;
            out_value_reg <= report_word(stats, word_idx_reg);
            out_last_reg  <= (word_idx_reg == RPT_LAST);
        end
    end

    fsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (byte_ch.data_byte),
        .clear      (clear_stats),
        .mark_rd    (mark_rd),
        .mark_raddr (mark_raddr),
        .mark_wr    (mark_wr),
        .stats      (stats)
    );

    // clearing pass owns the write port
    assign ram_we    = ram_clear || mark_wr.en;
    assign ram_waddr = ram_clear ? clr_addr_reg : mark_wr.addr;
    assign ram_wdata = ram_clear ? 1'b0 : mark_wr.data;

    fsp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_READ_LEN)
    ) u_mark_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rd)
    );

    assign byte_ch.ready          = in_ready;
    assign report_ch.valid        = out_valid_reg;
    assign report_ch.report_index = out_index_reg;
    assign report_ch.report_value = out_value_reg;
    assign report_ch.report_last  = out_last_reg;

endmodule

[rtl/fsp_checker.sv]
// port-level checks on the profiler, bound to the top level
module fsp_checker
    import fsp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              in_eos,
    input logic              out_valid,
    input logic              out_ready,
    input logic [IDX_W-1:0]  out_index,
    input logic              out_last
);

    // last flag only on the final report word
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |-> out_index == RPT_LAST)
        else $error("report_last on a word other than the final one");

    // report words follow each other without gaps or skipped indexes
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=>
            out_valid && (out_index == $past(out_index) + 5'd1))
        else $error("report word missing or out of order");

    // no byte taken while a report run is still being sent
    a_no_input_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready)
        else $error("byte request taken during a report run");

    // end of stream stops the byte channel at once
    a_eos_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_eos |=> !in_ready)
        else $error("byte channel still ready after end of stream");

endmodule

bind fastq_stream_profiler_unit fsp_checker u_fsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_ch.valid),
    .in_ready  (byte_ch.ready),
    .in_eos    (byte_ch.end_of_stream),
    .out_valid (report_ch.valid),
    .out_ready (report_ch.ready),
    .out_index (report_ch.report_index),
    .out_last  (report_ch.report_last)
);
